// ===== rtl/assert_macros.svh =====
// Assertion helpers for the timer and status unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// assert a property on the rising clock edge, disabled during reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// assert a property on the rising clock edge, checked during reset as well
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

// ===== rtl/fmts_pkg.sv =====
// ----------------------------------------------------------------------------
// fmts_pkg
// Shared types and constants for the FM chip timer and status unit.
// ----------------------------------------------------------------------------
`default_nettype none
package fmts_pkg;
    typedef enum logic [1:0] {
        OP_ADVANCE = 2'd0,
        OP_WRITE   = 2'd1,
        OP_READ    = 2'd2,
        OP_RESET   = 2'd3
    } t_opcode;

    localparam logic [7:0] REG_TA_HI  = 8'h24;
    localparam logic [7:0] REG_TA_LO  = 8'h25;
    localparam logic [7:0] REG_TB     = 8'h26;
    localparam logic [7:0] REG_CTRL   = 8'h27;
    localparam logic [7:0] REG_KEY_ON = 8'h28;
    localparam logic [4:0] PHASES     = 5'd24;

    // control bit positions
    localparam int CB_LOCK   = 0;
    localparam int CB_LOAD   = 1;
    localparam int CB_ENABLE = 2;
    localparam int CB_RESET  = 3;
    localparam int CB_LATCH  = 4;
    localparam int CB_FLAG   = 5;
    localparam int CB_OVF    = 6;

    // controller to datapath
    typedef struct packed {
        logic load;       // capture the input beat
        logic apply;      // apply write / read / reset
        logic prescale;   // subtract one phase worth of master cycles
        logic phase;      // run one internal phase
        logic finish;     // store remainder and present the result
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic     phase_due;
        t_opcode  op;
    } t_sts;
endpackage
`default_nettype wire

// ===== rtl/fmts_ctrl.sv =====
// ----------------------------------------------------------------------------
// fmts_ctrl
// Sequencer: takes a beat, applies it or steps phases one per cycle, presents the result.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module fmts_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_stall,
    output logic               o_valid,
    input  wire logic          i_stall,
    input  wire fmts_pkg::t_sts i_sts,
    output fmts_pkg::t_cmd     o_cmd
);
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_STEP = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   in_acc, out_acc;

    // take a beat while idle, or in the cycle the finished result leaves
    assign out_acc = o_valid && !i_stall;
    assign o_stall = !(r_state == S_IDLE || (r_state == S_OUT && out_acc));
    assign in_acc  = i_valid && !o_stall;
    assign o_valid = (r_state == S_OUT);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.load = in_acc;
        case (r_state)
            S_IDLE: begin
                if (in_acc) n_state = S_EXEC;
            end
            S_EXEC: begin
                if (i_sts.op == fmts_pkg::OP_ADVANCE) begin
                    n_state = S_STEP;
                end else begin
                    o_cmd.apply = 1'b1;
                    n_state     = S_OUT;
                end
            end
            S_STEP: begin
                if (i_sts.phase_due) begin
                    o_cmd.prescale = 1'b1;
                    o_cmd.phase    = 1'b1;
                end else begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_OUT;
                end
            end
            S_OUT: begin
                if (in_acc) n_state = S_EXEC;
                else if (out_acc) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    `ASSERT_ALWAYS(a_onehot, i_clk, !i_rst_n || $onehot(r_state), "state not one-hot")
    `ASSERT_CLK(a_no_take_busy, i_clk, i_rst_n,
        (r_state == S_STEP || r_state == S_EXEC) |-> o_stall, "beat taken while busy")
    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n,
        (o_valid && i_stall) |=> o_valid, "result dropped under stall")
endmodule
`default_nettype wire

// ===== rtl/fmts_dp.sv =====
// ----------------------------------------------------------------------------
// fmts_dp
// Datapath: prescaler, phase counter, busy countdown, timers A and B, status.
// ----------------------------------------------------------------------------
`default_nettype none
module fmts_dp #(
    parameter int MASTER_PER_PHASE = 42,
    parameter int BUSY_PHASES      = 32
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic [1:0]     i_opcode,
    input  wire logic [1:0]     i_addr_low,
    input  wire logic [7:0]     i_value,
    input  wire logic [11:0]    i_master_cycles,
    input  wire fmts_pkg::t_cmd i_cmd,
    output fmts_pkg::t_sts      o_sts,
    output logic [7:0]          o_status,
    output logic [5:0]          o_key_on_mask
);
    localparam logic [12:0] MPP  = 13'(MASTER_PER_PHASE);
    localparam logic [5:0]  BUSY = 6'(BUSY_PHASES);

    logic [1:0]  r_op, r_al;
    logic [7:0]  r_val;
    logic [12:0] r_total;
    logic [5:0]  r_rem;
    logic [4:0]  r_phase;
    logic        r_busy;
    logic [5:0]  r_busy_cnt;
    logic [7:0]  r_held;
    logic [7:0]  r_alatch [2];
    logic [5:0]  r_keys;
    logic [9:0]  r_ta_cnt, r_ta_per;
    logic [6:0]  r_ta_cb, r_tb_cb;
    logic [7:0]  r_tb_cnt, r_tb_per;
    logic [4:0]  r_tb_sub;

    // phase step next values
    logic [6:0]  ca, cb;
    logic        lda, ldb;
    logic [10:0] ta;
    logic [8:0]  tb;
    logic [4:0]  sub;
    logic [7:0]  reg_sel;
    logic [2:0]  ch;

    assign o_sts.phase_due = (r_total >= MPP);
    assign o_sts.op        = fmts_pkg::t_opcode'(r_op);
    assign o_status        = r_held;
    assign o_key_on_mask   = r_keys;
    assign reg_sel         = r_alatch[r_al[1]];
    assign ch              = {1'b0, r_val[1:0]} + (r_val[2] ? 3'd3 : 3'd0);

    always_comb begin
        // timer A front
        ca  = r_ta_cb;
        lda = ca[fmts_pkg::CB_OVF];
        if (r_phase == 5'd2) begin
            if (!ca[fmts_pkg::CB_LOCK] && ca[fmts_pkg::CB_LOAD]) lda = 1'b1;
            ca[fmts_pkg::CB_LOCK] = ca[fmts_pkg::CB_LOAD];
        end
        ta = {1'b0, ca[fmts_pkg::CB_LATCH] ? r_ta_per : r_ta_cnt};
        ca[fmts_pkg::CB_LATCH] = lda;
        if (r_phase == 5'd1 && ca[fmts_pkg::CB_LOCK]) ta = ta + 11'd1;
        if (ca[fmts_pkg::CB_RESET]) begin
            ca[fmts_pkg::CB_RESET] = 1'b0;
            ca[fmts_pkg::CB_FLAG]  = 1'b0;
        end else if (ca[fmts_pkg::CB_OVF] && ca[fmts_pkg::CB_ENABLE]) begin
            ca[fmts_pkg::CB_FLAG] = 1'b1;
        end
        ca[fmts_pkg::CB_OVF] = ta[10];

        // timer B front
        cb  = r_tb_cb;
        ldb = cb[fmts_pkg::CB_OVF];
        if (r_phase == 5'd2) begin
            if (!cb[fmts_pkg::CB_LOCK] && cb[fmts_pkg::CB_LOAD]) ldb = 1'b1;
            cb[fmts_pkg::CB_LOCK] = cb[fmts_pkg::CB_LOAD];
        end
        tb = {1'b0, cb[fmts_pkg::CB_LATCH] ? r_tb_per : r_tb_cnt};
        cb[fmts_pkg::CB_LATCH] = ldb;
        sub = (r_phase == 5'd1) ? r_tb_sub + 5'd1 : r_tb_sub;
        if (sub == 5'h10 && cb[fmts_pkg::CB_LOCK]) tb = tb + 9'd1;
        sub = {1'b0, sub[3:0]};
        if (cb[fmts_pkg::CB_RESET]) begin
            cb[fmts_pkg::CB_RESET] = 1'b0;
            cb[fmts_pkg::CB_FLAG]  = 1'b0;
        end else if (cb[fmts_pkg::CB_OVF] && cb[fmts_pkg::CB_ENABLE]) begin
            cb[fmts_pkg::CB_FLAG] = 1'b1;
        end
        cb[fmts_pkg::CB_OVF] = tb[8];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_opcode;
            r_al  <= i_addr_low;
            r_val <= i_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_cmd.apply && r_op == fmts_pkg::OP_RESET)) begin
            r_total    <= '0;
            r_rem      <= '0;
            r_phase    <= '0;
            r_busy     <= 1'b0;
            r_busy_cnt <= '0;
            r_held     <= '0;
            r_alatch[0] <= '0;
            r_alatch[1] <= '0;
            r_keys     <= '0;
            r_ta_cnt   <= '0;
            r_ta_per   <= '0;
            r_ta_cb    <= '0;
            r_tb_cnt   <= '0;
            r_tb_sub   <= '0;
            r_tb_per   <= '0;
            r_tb_cb    <= '0;
        end else begin
            // sum loaded with the beat, ahead of the phase loop
            if (i_cmd.load) r_total <= 13'(r_rem) + 13'(i_master_cycles);
            if (i_cmd.prescale) r_total <= r_total - MPP;
            if (i_cmd.finish) r_rem <= r_total[5:0];
            if (i_cmd.phase) begin
                r_busy <= (r_busy_cnt != '0);
                if (r_busy_cnt != '0) r_busy_cnt <= r_busy_cnt - 6'd1;
                r_ta_cb  <= ca;
                r_ta_cnt <= ta[9:0];
                r_tb_cb  <= cb;
                r_tb_cnt <= tb[7:0];
                r_tb_sub <= sub;
                r_phase  <= (r_phase == fmts_pkg::PHASES - 5'd1) ? '0 : r_phase + 5'd1;
            end
            if (i_cmd.apply && r_op == fmts_pkg::OP_WRITE) begin
                if (!r_al[0]) begin
                    r_alatch[r_al[1]] <= r_val;
                end else begin
                    r_busy_cnt <= BUSY;
                    if (!r_al[1]) begin
                        case (reg_sel)
                            fmts_pkg::REG_TA_HI: r_ta_per[9:2] <= r_val;
                            fmts_pkg::REG_TA_LO: r_ta_per[1:0] <= r_val[1:0];
                            fmts_pkg::REG_TB:    r_tb_per      <= r_val;
                            fmts_pkg::REG_CTRL: begin
                                r_ta_cb[fmts_pkg::CB_LOAD]   <= r_val[0];
                                r_ta_cb[fmts_pkg::CB_ENABLE] <= r_val[2];
                                r_ta_cb[fmts_pkg::CB_RESET]  <= r_val[4];
                                r_tb_cb[fmts_pkg::CB_LOAD]   <= r_val[1];
                                r_tb_cb[fmts_pkg::CB_ENABLE] <= r_val[3];
                                r_tb_cb[fmts_pkg::CB_RESET]  <= r_val[5];
                            end
                            fmts_pkg::REG_KEY_ON: begin
                                if (r_val[1:0] != 2'd3)
                                    r_keys[ch] <= (r_val[7:4] != 4'd0);
                            end
                            default: ;
                        endcase
                    end
                end
            end
            if (i_cmd.apply && r_op == fmts_pkg::OP_READ && r_al == 2'd0)
                r_held <= {r_busy, 5'd0, r_tb_cb[fmts_pkg::CB_FLAG],
                           r_ta_cb[fmts_pkg::CB_FLAG]};
        end
    end
endmodule
`default_nettype wire

// ===== rtl/fm_chip_timer_status_unit.sv =====
// ----------------------------------------------------------------------------
// fm_chip_timer_status_unit
// Timer A / timer B and status logic of an FM sound chip.
//
//   channel  | handshake          | payload
//   input    | i_valid / o_stall  | i_opcode, i_addr_low, i_value, i_master_cycles
//   output   | o_valid / i_stall  | o_status, o_key_on_mask
//
// Write, read and reset beats go from EXEC straight to OUT; an advance steps
// one internal phase per cycle (floor((rem + cycles) / 42) phases) and then
// stores the remainder. The controller runs the phase loop on phase_due.
// Reset is synchronous on i_rst_n; OP_RESET clears timers, status and keys.
// A stalled result is held; the next beat is taken as it leaves.
// ----------------------------------------------------------------------------
`default_nettype none
module fm_chip_timer_status_unit #(
    parameter int MASTER_PER_PHASE = 42,
    parameter int BUSY_PHASES      = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_opcode,
    input  wire logic [1:0]  i_addr_low,
    input  wire logic [7:0]  i_value,
    input  wire logic [11:0] i_master_cycles,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [7:0]       o_status,
    output logic [5:0]       o_key_on_mask
);
    fmts_pkg::t_cmd cmd;
    fmts_pkg::t_sts sts;

    fmts_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    fmts_dp #(
        .MASTER_PER_PHASE (MASTER_PER_PHASE),
        .BUSY_PHASES      (BUSY_PHASES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_opcode        (i_opcode),
        .i_addr_low      (i_addr_low),
        .i_value         (i_value),
        .i_master_cycles (i_master_cycles),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .o_status        (o_status),
        .o_key_on_mask   (o_key_on_mask)
    );
endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the FM chip timer and status unit. A local model
// of the prescaler, busy countdown, timers and key-on mask predicts the
// status and key mask for every beat; a monitor compares them in order.
// ----------------------------------------------------------------------------
module tb_top;
    localparam int PER_PHASE  = 42;
    localparam int BUSY_LEN   = 32;
    localparam int CYCLE_CAP  = 3_000_000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [1:0]  i_opcode = '0;
    logic [1:0]  i_addr_low = '0;
    logic [7:0]  i_value = '0;
    logic [11:0] i_master_cycles = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [7:0]  o_status;
    logic [5:0]  o_key_on_mask;

    fm_chip_timer_status_unit u_top (.*);

    always #5 i_clk = ~i_clk;

    // chip model state
    logic [5:0] m_rem;
    logic [4:0] m_phase;
    logic       m_busy;
    logic [5:0] m_busy_cnt;
    logic [7:0] m_status;
    logic [7:0] m_addr [2];
    logic [5:0] m_keys;
    logic [9:0] m_ta_cnt, m_ta_per;
    logic [6:0] m_ta_ctl, m_tb_ctl;
    logic [7:0] m_tb_cnt, m_tb_per;
    logic [4:0] m_tb_sub;

    typedef struct {
        logic [7:0] status;
        logic [5:0] keys;
    } t_chip_out;
    t_chip_out pending_outputs [$];

    int  errors = 0;
    int  beats_sent = 0;
    int  beats_seen = 0;
    int  cycles = 0;
    bit  idle_quiet = 0;

    function automatic void chip_clear();
        m_rem = '0; m_phase = '0; m_busy = 0; m_busy_cnt = '0; m_status = '0;
        m_addr[0] = '0; m_addr[1] = '0; m_keys = '0;
        m_ta_cnt = '0; m_ta_per = '0; m_ta_ctl = '0;
        m_tb_cnt = '0; m_tb_per = '0; m_tb_ctl = '0; m_tb_sub = '0;
    endfunction

    function automatic logic [10:0] timer_load(ref logic [6:0] ctl,
                                                input logic [10:0] cnt,
                                                input logic [10:0] per);
        logic ld;
        logic [10:0] t;
        ld = ctl[fmts_pkg::CB_OVF];
        if (m_phase == 5'd2) begin
            if (!ctl[fmts_pkg::CB_LOCK] && ctl[fmts_pkg::CB_LOAD]) ld = 1'b1;
            ctl[fmts_pkg::CB_LOCK] = ctl[fmts_pkg::CB_LOAD];
        end
        t = ctl[fmts_pkg::CB_LATCH] ? per : cnt;
        ctl[fmts_pkg::CB_LATCH] = ld;
        return t;
    endfunction

    function automatic void timer_flag(ref logic [6:0] ctl, input logic ovf);
        if (ctl[fmts_pkg::CB_RESET]) begin
            ctl[fmts_pkg::CB_RESET] = 1'b0;
            ctl[fmts_pkg::CB_FLAG]  = 1'b0;
        end else if (ctl[fmts_pkg::CB_OVF] && ctl[fmts_pkg::CB_ENABLE]) begin
            ctl[fmts_pkg::CB_FLAG] = 1'b1;
        end
        ctl[fmts_pkg::CB_OVF] = ovf;
    endfunction

    function automatic void chip_phase();
        logic [10:0] t;
        m_busy = (m_busy_cnt != 0);
        if (m_busy_cnt != 0) m_busy_cnt--;
        t = timer_load(m_ta_ctl, {1'b0, m_ta_cnt}, {1'b0, m_ta_per});
        if (m_phase == 5'd1 && m_ta_ctl[fmts_pkg::CB_LOCK]) t++;
        timer_flag(m_ta_ctl, t[10]);
        m_ta_cnt = t[9:0];
        t = timer_load(m_tb_ctl, {3'b0, m_tb_cnt}, {3'b0, m_tb_per});
        if (m_phase == 5'd1) m_tb_sub = m_tb_sub + 5'd1;
        if (m_tb_sub == 5'h10 && m_tb_ctl[fmts_pkg::CB_LOCK]) t++;
        m_tb_sub[4] = 1'b0;
        timer_flag(m_tb_ctl, t[8]);
        m_tb_cnt = t[7:0];
        m_phase = (m_phase == fmts_pkg::PHASES - 5'd1) ? 5'd0 : m_phase + 5'd1;
    endfunction

    function automatic void chip_data(logic port, logic [7:0] v);
        logic [2:0] ch;
        m_busy_cnt = 6'(BUSY_LEN);
        if (port) return;
        case (m_addr[0])
            fmts_pkg::REG_TA_HI:  m_ta_per[9:2] = v;
            fmts_pkg::REG_TA_LO:  m_ta_per[1:0] = v[1:0];
            fmts_pkg::REG_TB:     m_tb_per = v;
            fmts_pkg::REG_CTRL: begin
                m_ta_ctl[fmts_pkg::CB_LOAD] = v[0]; m_ta_ctl[fmts_pkg::CB_ENABLE] = v[2];
                m_ta_ctl[fmts_pkg::CB_RESET] = v[4];
                m_tb_ctl[fmts_pkg::CB_LOAD] = v[1]; m_tb_ctl[fmts_pkg::CB_ENABLE] = v[3];
                m_tb_ctl[fmts_pkg::CB_RESET] = v[5];
            end
            fmts_pkg::REG_KEY_ON: begin
                if (v[1:0] != 2'd3) begin
                    ch = {1'b0, v[1:0]} + (v[2] ? 3'd3 : 3'd0);
                    m_keys[ch] = (v[7:4] != 0);
                end
            end
            default: ;
        endcase
    endfunction

    function automatic t_chip_out chip_apply(fmts_pkg::t_opcode op, logic [1:0] al,
                                             logic [7:0] v, logic [11:0] mc);
        int total;
        t_chip_out r;
        case (op)
            fmts_pkg::OP_ADVANCE: begin
                total = m_rem + mc;
                while (total >= PER_PHASE) begin
                    total -= PER_PHASE;
                    chip_phase();
                end
                m_rem = 6'(total);
            end
            fmts_pkg::OP_WRITE: begin
                if (!al[0]) m_addr[al[1]] = v;
                else chip_data(al[1], v);
            end
            fmts_pkg::OP_READ: begin
                if (al == 2'd0)
                    m_status = {m_busy, 5'd0, m_tb_ctl[fmts_pkg::CB_FLAG],
                                m_ta_ctl[fmts_pkg::CB_FLAG]};
            end
            default: chip_clear();
        endcase
        r.status = m_status;
        r.keys = m_keys;
        return r;
    endfunction

    // send one beat, holding it while stalled
    task automatic send_beat(fmts_pkg::t_opcode op, logic [1:0] al, logic [7:0] v,
                             logic [11:0] mc);
        while (!idle_quiet && $urandom_range(99) < 7) @(posedge i_clk);
        pending_outputs.push_back(chip_apply(op, al, v, mc));
        i_valid <= 1'b1;
        i_opcode <= op;
        i_addr_low <= al;
        i_value <= v;
        i_master_cycles <= mc;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        i_valid <= 1'b0;
        beats_sent++;
        // the unit is busy for at least this cycle
        @(posedge i_clk);
    endtask

    task automatic reg_write(logic port, logic [7:0] a, logic [7:0] d);
        send_beat(fmts_pkg::OP_WRITE, {port, 1'b0}, a, 12'($urandom));
        send_beat(fmts_pkg::OP_WRITE, {port, 1'b1}, d, 12'($urandom));
    endtask

    task automatic drain();
        while (pending_outputs.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed();
        send_beat(fmts_pkg::OP_READ, 2'd0, 8'h00, 12'd0);
        send_beat(fmts_pkg::OP_ADVANCE, 2'd3, 8'hFF, 12'd0);
        reg_write(1'b0, fmts_pkg::REG_TA_HI, 8'hFF);
        reg_write(1'b0, fmts_pkg::REG_TA_LO, 8'h03);
        reg_write(1'b0, fmts_pkg::REG_TB, 8'hFF);
        reg_write(1'b0, fmts_pkg::REG_CTRL, 8'h3F);
        reg_write(1'b0, fmts_pkg::REG_KEY_ON, 8'hF6);
        reg_write(1'b0, fmts_pkg::REG_KEY_ON, 8'hF3);
        reg_write(1'b1, fmts_pkg::REG_TB, 8'h00);
        send_beat(fmts_pkg::OP_ADVANCE, 2'd0, 8'h00, 12'd4095);
        send_beat(fmts_pkg::OP_READ, 2'd1, 8'h00, 12'd0);
        send_beat(fmts_pkg::OP_READ, 2'd0, 8'hFF, 12'hFFF);
        send_beat(fmts_pkg::OP_RESET, 2'd2, 8'hAA, 12'd5);
        send_beat(fmts_pkg::OP_READ, 2'd0, 8'h00, 12'd0);
    endtask

    // timer and key-on programming sequences with reads, rare resets and mostly small advances
    task automatic test_timers(int n);
        int k;
        for (k = 0; k < n; k++) begin
            case ($urandom_range(11))
                0: reg_write(1'b0, fmts_pkg::REG_TA_HI, 8'($urandom));
                1: reg_write(1'b0, fmts_pkg::REG_TA_LO, 8'($urandom));
                2: reg_write(1'b0, fmts_pkg::REG_TB, 8'($urandom));
                3: reg_write(1'b0, fmts_pkg::REG_CTRL, 8'($urandom));
                4: reg_write(1'b0, fmts_pkg::REG_KEY_ON, 8'($urandom));
                5: send_beat(fmts_pkg::OP_READ, 2'($urandom), 8'($urandom),
                             12'($urandom));
                6: send_beat(fmts_pkg::OP_WRITE, 2'($urandom), 8'($urandom),
                             12'($urandom));
                7: if ($urandom_range(40) == 0)
                       send_beat(fmts_pkg::OP_RESET, 2'($urandom), 8'($urandom),
                                 12'($urandom));
                   else
                       send_beat(fmts_pkg::OP_READ, 2'd0, 8'($urandom), 12'($urandom));
                8: send_beat(fmts_pkg::OP_ADVANCE, 2'($urandom), 8'($urandom),
                             ($urandom_range(19) == 0) ? 12'($urandom) :
                             12'($urandom_range(200)));
                default: send_beat(fmts_pkg::OP_READ, 2'd0, 8'($urandom),
                                   12'($urandom));
            endcase
        end
    endtask

    task automatic test_quiet();
        idle_quiet = 1;
        test_timers(150);
        idle_quiet = 0;
        // hold off until the pipeline is empty
        drain();
        test_timers(100);
    endtask

    // result monitor
    always @(posedge i_clk) begin
        t_chip_out exp_out;
        cycles <= cycles + 1;
        if (i_rst_n && o_valid && !i_stall) begin
            beats_seen <= beats_seen + 1;
            if (pending_outputs.size() == 0) begin
                $error("unexpected result status=%h keys=%h", o_status, o_key_on_mask);
                errors++;
            end else begin
                exp_out = pending_outputs.pop_front();
                if (o_status !== exp_out.status) begin
                    $error("status exp=%h got=%h", exp_out.status, o_status);
                    errors++;
                end
                if (o_key_on_mask !== exp_out.keys) begin
                    $error("key_on_mask exp=%h got=%h", exp_out.keys, o_key_on_mask);
                    errors++;
                end
            end
        end
        if (cycles > CYCLE_CAP) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (idle_quiet) i_stall <= 1'b0;
        else i_stall <= ($urandom_range(99) < 7);
    end

    initial begin
        chip_clear();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_quiet();
        test_timers(970);
        drain();
        repeat (200) @(posedge i_clk);
        $display("Sent %0d beats (timer, key-on, read, reset, advance mixes);", beats_sent);
        $display("checked %0d results.", beats_seen);
        if (errors == 0 && pending_outputs.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
